>>> design/erfp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the ERF Ethernet record header parser.
// No dependencies; every other design file but erfp_if refers to this package.
package erfp_pkg;

  localparam logic [7:0] HDR_SIZE  = 8'd16;
  localparam logic [7:0] EXT_SIZE  = 8'd8;
  localparam logic [7:0] META_SIZE = 8'd2;
  localparam logic [6:0] TYPE_ETH  = 7'd2;

  // hard limit on followed extension headers (0..16)
  localparam logic [4:0] MAX_EXTENSIONS = 5'd16;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NEED_MORE   = 3'd1,
    ST_TRUNCATED   = 3'd2,
    ST_UNSUPPORTED = 3'd3,
    ST_INVALID_LEN = 3'd4,
    ST_TOO_MANY    = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic        first_byte;
    logic        last_byte;
    logic [31:0] captured_length;
  } item_t;

  // input register contents as seen by the parser
  typedef struct packed {
    logic  valid;
    item_t item;
  } in_stage_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  record_flags;
    logic [15:0] hdr_rec_len;
    logic [15:0] hdr_wire_len;
    logic [7:0]  metadata_offset;
    logic [7:0]  metadata_first;
    logic [7:0]  metadata_second;
    logic [7:0]  frame_offset;
    logic [15:0] network_bytes;
  } result_t;

endpackage

>>> design/erfp_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the byte input and the verdict output.
// Standalone; field widths follow erfp_pkg.
interface erfp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_value;
  logic        first_byte;
  logic        last_byte;
  logic [31:0] captured_length;

  modport source (output valid, byte_value, first_byte, last_byte, captured_length,
                  input ready);
  modport sink   (input valid, byte_value, first_byte, last_byte, captured_length,
                  output ready);
endinterface

interface erfp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  record_flags;
  logic [15:0] hdr_rec_len;
  logic [15:0] hdr_wire_len;
  logic [7:0]  metadata_offset;
  logic [7:0]  metadata_first;
  logic [7:0]  metadata_second;
  logic [7:0]  frame_offset;
  logic [15:0] network_bytes;

  modport source (output valid, status, record_flags, hdr_rec_len, hdr_wire_len,
                  metadata_offset, metadata_first, metadata_second, frame_offset,
                  network_bytes, input ready);
  modport sink   (input valid, status, record_flags, hdr_rec_len, hdr_wire_len,
                  metadata_offset, metadata_first, metadata_second, frame_offset,
                  network_bytes, output ready);
endinterface

>>> design/erf_eth_record_header_parser.sv
`timescale 1ns / 1ps
// ERF Ethernet record header parser, top level.
// Depends on erfp_pkg, erfp_if, erfp_in_stage and erfp_parser.
//
// in_chan carries one byte of a captured ERF record prefix per request, with
// first_byte marking a new record (captured_length is sampled there) and
// last_byte marking the final available byte. out_chan carries at most one
// verdict per record: status plus header fields, offsets and lengths, all
// fields but status zero when status is not ok.
//
// One byte is accepted every cycle while the receiver keeps up. A byte passes
// through the input register and the parse logic into the verdict register:
// the byte that settles the verdict is held in the input register, and the
// verdict register loads when the parser takes it, driving out_chan.valid. The
// rate is set by the update of the per-record state from each byte.
//
// Reset (synchronous, rst_n low) empties both registers and leaves the parser
// idle: bytes before the first first_byte are dropped. While the receiver
// holds out_chan.ready low with a verdict pending, bytes that give no verdict
// still flow; a byte that would give one waits in the input register, and
// in_chan.ready drops once that register is full.
module erf_eth_record_header_parser #(
  parameter logic [4:0] MAX_EXTENSIONS = erfp_pkg::MAX_EXTENSIONS
) (
  input  logic       clk,
  input  logic       rst_n,
  erfp_in_if.sink    in_chan,
  erfp_out_if.source out_chan
);

  erfp_pkg::in_stage_t stage;
  logic                take;

  erfp_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .take    (take),
    .stage   (stage)
  );

  erfp_parser #(
    .MAX_EXTENSIONS (MAX_EXTENSIONS)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .stage    (stage),
    .take     (take),
    .out_chan (out_chan)
  );

  a_ok_net_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.status == erfp_pkg::ST_OK |->
      out_chan.frame_offset == out_chan.metadata_offset + 8'd2)
    else $error("network offset does not follow metadata offset");

  a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.status != erfp_pkg::ST_OK |->
      out_chan.record_flags == 8'd0 && out_chan.hdr_rec_len == 16'd0 &&
      out_chan.hdr_wire_len == 16'd0 && out_chan.metadata_offset == 8'd0 &&
      out_chan.metadata_first == 8'd0 && out_chan.metadata_second == 8'd0 &&
      out_chan.frame_offset == 8'd0 && out_chan.network_bytes == 16'd0)
    else $error("error verdict carries nonzero fields");

  a_held_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    stage.valid && !take |=> stage.valid)
    else $error("held input request dropped");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> stage.valid && !take)
    else $error("input stalled with free input register");

endmodule

>>> design/erfp_in_stage.sv
`timescale 1ns / 1ps
// Input register for the byte channel: holds one request until the parser takes it.
// Depends on erfp_pkg and erfp_in_if.
module erfp_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  erfp_in_if.sink             in_chan,
  input  logic                take,
  output erfp_pkg::in_stage_t stage
);

  logic            valid_r, valid_nxt;
  erfp_pkg::item_t item_r;
  logic            accept;

  // refill in the same cycle the held request is taken
  assign in_chan.ready = !valid_r || take;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.byte_value      <= in_chan.byte_value;
      item_r.first_byte      <= in_chan.first_byte;
      item_r.last_byte       <= in_chan.last_byte;
      item_r.captured_length <= in_chan.captured_length;
    end
  end

  assign stage = {valid_r, item_r};

endmodule

>>> design/erfp_parser.sv
`timescale 1ns / 1ps
// Per-record header state, verdict logic and the verdict output register.
// Depends on erfp_pkg and erfp_out_if.
module erfp_parser #(
  parameter logic [4:0] MAX_EXTENSIONS = erfp_pkg::MAX_EXTENSIONS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  erfp_pkg::in_stage_t stage,
  output logic                take,
  erfp_out_if.source          out_chan
);

  typedef struct packed {
    logic              hit;
    erfp_pkg::status_t code;
  } verdict_t;

  // record state
  logic [7:0]  pos_r, pos_nxt;
  logic [31:0] cap_r, cap_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [15:0] rlen_r, rlen_nxt;
  logic [15:0] wlen_r, wlen_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        more_r, more_nxt;
  logic [7:0]  meta_r, meta_nxt;
  logic        nmore_r, nmore_nxt;
  logic        done_r, done_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  erfp_pkg::result_t res_r, res_nxt;

  // current view, with a first byte clearing the record
  logic [7:0]  c_pos, c_type, c_flags, c_meta, off, net;
  logic [31:0] c_cap, net_bytes;
  logic [15:0] c_rlen, c_wlen;
  logic [4:0]  c_cnt;
  logic        c_more, c_nmore;
  logic [7:0]  b;
  logic        first, active, emit, upd;
  verdict_t    vd;

  function automatic verdict_t chain_check(input logic more, input logic [4:0] cnt,
                                           input logic [31:0] cap);
    verdict_t   v;
    logic [7:0] o;
    o      = erfp_pkg::HDR_SIZE + {cnt, 3'b000};
    v.hit  = 1'b0;
    v.code = erfp_pkg::ST_OK;
    if (more) begin
      if (cnt >= MAX_EXTENSIONS) begin
        v.hit  = 1'b1;
        v.code = erfp_pkg::ST_TOO_MANY;
      end else if (cap < {24'd0, o + erfp_pkg::EXT_SIZE}) begin
        v.hit  = 1'b1;
        v.code = erfp_pkg::ST_TRUNCATED;
      end
    end else if (cap < {24'd0, o + erfp_pkg::META_SIZE}) begin
      v.hit  = 1'b1;
      v.code = erfp_pkg::ST_TRUNCATED;
    end
    return v;
  endfunction

  always_comb begin
    b       = stage.item.byte_value;
    first   = stage.item.first_byte;
    active  = first || !done_r;

    c_pos   = first ? 8'd0 : pos_r;
    c_cap   = first ? stage.item.captured_length : cap_r;
    c_type  = first ? 8'd0 : type_r;
    c_flags = first ? 8'd0 : flags_r;
    c_rlen  = first ? 16'd0 : rlen_r;
    c_wlen  = first ? 16'd0 : wlen_r;
    c_cnt   = first ? 5'd0 : cnt_r;
    c_more  = first ? 1'b0 : more_r;
    c_meta  = first ? 8'd0 : meta_r;
    c_nmore = first ? 1'b0 : nmore_r;

    pos_nxt   = c_pos + 8'd1;
    cap_nxt   = c_cap;
    type_nxt  = c_type;
    flags_nxt = c_flags;
    rlen_nxt  = c_rlen;
    wlen_nxt  = c_wlen;
    cnt_nxt   = c_cnt;
    more_nxt  = c_more;
    meta_nxt  = c_meta;
    nmore_nxt = c_nmore;

    off       = erfp_pkg::HDR_SIZE + {c_cnt, 3'b000};
    net       = off + erfp_pkg::META_SIZE;
    net_bytes = c_cap - {24'd0, net};

    vd.hit  = 1'b0;
    vd.code = erfp_pkg::ST_OK;

    res_nxt = '0;

    if (first && c_cap < {24'd0, erfp_pkg::HDR_SIZE}) begin
      vd.hit  = 1'b1;
      vd.code = erfp_pkg::ST_TRUNCATED;
    end else if (c_pos < erfp_pkg::HDR_SIZE) begin
      case (c_pos)
        8'd8:    type_nxt  = b;
        8'd9:    flags_nxt = b;
        8'd10:   rlen_nxt  = {b, 8'd0};
        8'd11:   rlen_nxt  = {c_rlen[15:8], b};
        8'd14:   wlen_nxt  = {b, 8'd0};
        8'd15:   wlen_nxt  = {c_wlen[15:8], b};
        default: ;
      endcase
      // header complete: checks see this byte's update
      if (c_pos == erfp_pkg::HDR_SIZE - 8'd1) begin
        if (type_nxt[6:0] != erfp_pkg::TYPE_ETH) begin
          vd.hit  = 1'b1;
          vd.code = erfp_pkg::ST_UNSUPPORTED;
        end else if ({16'd0, rlen_nxt} != c_cap || wlen_nxt == 16'd0) begin
          vd.hit  = 1'b1;
          vd.code = erfp_pkg::ST_INVALID_LEN;
        end else begin
          more_nxt = type_nxt[7];
          cnt_nxt  = 5'd0;
          vd       = chain_check(type_nxt[7], 5'd0, c_cap);
        end
      end
    end else if (c_more) begin
      if (c_pos == off) begin
        nmore_nxt = b[7];
      end
      if (c_pos == off + erfp_pkg::EXT_SIZE - 8'd1) begin
        cnt_nxt  = c_cnt + 5'd1;
        more_nxt = c_nmore;
        vd       = chain_check(c_nmore, c_cnt + 5'd1, c_cap);
      end
    end else begin
      if (c_pos == off) begin
        meta_nxt = b;
      end else if (c_pos == off + 8'd1) begin
        vd.hit = 1'b1;
        if (net_bytes > {16'd0, c_wlen}) begin
          vd.code = erfp_pkg::ST_INVALID_LEN;
        end else begin
          vd.code                 = erfp_pkg::ST_OK;
          res_nxt.record_flags    = c_flags;
          res_nxt.hdr_rec_len     = c_rlen;
          res_nxt.hdr_wire_len    = c_wlen;
          res_nxt.metadata_offset = off;
          res_nxt.metadata_first  = c_meta;
          res_nxt.metadata_second = b;
          res_nxt.frame_offset    = net;
          res_nxt.network_bytes   = net_bytes[15:0];
        end
      end
    end

    if (!vd.hit && stage.item.last_byte) begin
      vd.hit  = 1'b1;
      vd.code = erfp_pkg::ST_NEED_MORE;
    end
    if (vd.code != erfp_pkg::ST_OK) begin
      res_nxt = '0;
    end
    res_nxt.status = vd.code;
    done_nxt       = vd.hit;

    emit = active && vd.hit;
    // a request with no verdict never waits on the output side
    take = stage.valid && (!emit || !out_valid_r || out_chan.ready);
    upd  = take && active;

    out_valid_nxt = out_valid_r;
    if (take && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (upd) begin
        done_r <= done_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      pos_r   <= pos_nxt;
      cap_r   <= cap_nxt;
      type_r  <= type_nxt;
      flags_r <= flags_nxt;
      rlen_r  <= rlen_nxt;
      wlen_r  <= wlen_nxt;
      cnt_r   <= cnt_nxt;
      more_r  <= more_nxt;
      meta_r  <= meta_nxt;
      nmore_r <= nmore_nxt;
    end
    if (take && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.status          = res_r.status;
  assign out_chan.record_flags    = res_r.record_flags;
  assign out_chan.hdr_rec_len     = res_r.hdr_rec_len;
  assign out_chan.hdr_wire_len    = res_r.hdr_wire_len;
  assign out_chan.metadata_offset = res_r.metadata_offset;
  assign out_chan.metadata_first  = res_r.metadata_first;
  assign out_chan.metadata_second = res_r.metadata_second;
  assign out_chan.frame_offset    = res_r.frame_offset;
  assign out_chan.network_bytes   = res_r.network_bytes;

endmodule
